// ----- hw/rtl/spfc_pkg.sv -----
// Shared types and constants for the segment page fault classifier.
package spfc_pkg;

  // Table and page geometry
  localparam int unsigned MAX_SEGMENTS = 8;
  localparam int unsigned PAGE_BITS    = 12;
  localparam logic [31:0] LOAD_TYPE    = 32'd1;

  localparam int unsigned DATA_W     = 32;
  localparam int unsigned CFG_W      = 4;
  localparam int unsigned ZF_W       = 13;
  localparam int unsigned HIT_W      = 3;
  localparam int unsigned IDX_W      = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
  localparam int unsigned CNT_W      = $clog2(MAX_SEGMENTS + 1);
  localparam int unsigned PAGE_BYTES = 1 << PAGE_BITS;

  // Command codes on the input channel
  typedef enum logic {
    CMD_LOAD  = 1'b0,
    CMD_FAULT = 1'b1
  } cmd_e;

  // Shared arithmetic unit operations
  typedef enum logic {
    ALU_ADD = 1'b0,
    ALU_SUB = 1'b1
  } alu_op_e;

  typedef struct packed {
    alu_op_e            op;
    logic [DATA_W-1:0]  a;
    logic [DATA_W-1:0]  b;
  } alu_req_t;

  typedef struct packed {
    logic [DATA_W-1:0]  res;    // low word of sum or difference
    logic               co;     // carry out on add, borrow on subtract
    logic [DATA_W-1:0]  sat;    // add result clamped at all ones
  } alu_rsp_t;

  // One segment table entry
  typedef struct packed {
    logic               loadable;
    logic [DATA_W-1:0]  base;
    logic [DATA_W-1:0]  mem_size;
    logic [DATA_W-1:0]  file_size;
    logic [DATA_W-1:0]  file_start;
  } seg_entry_t;

endpackage

// ----- hw/rtl/spfc_alu.sv -----
// Shared 33-bit add/subtract unit with saturating add result.
module spfc_alu (
  input  spfc_pkg::alu_req_t req_i,
  output spfc_pkg::alu_rsp_t rsp_o
);

  logic [spfc_pkg::DATA_W:0] wide;

  // One adder serves both operations; top bit is carry or borrow
  always_comb begin
    unique case (req_i.op)
      spfc_pkg::ALU_ADD: wide = {1'b0, req_i.a} + {1'b0, req_i.b};
      spfc_pkg::ALU_SUB: wide = {1'b0, req_i.a} - {1'b0, req_i.b};
      default:           wide = '0;
    endcase
  end

  assign rsp_o.res = wide[spfc_pkg::DATA_W-1:0];
  assign rsp_o.co  = wide[spfc_pkg::DATA_W];
  assign rsp_o.sat = wide[spfc_pkg::DATA_W] ? '1 : wide[spfc_pkg::DATA_W-1:0];

endmodule

// ----- hw/rtl/spfc_seg_table.sv -----
// Segment table memory: one write port, one registered read port.
module spfc_seg_table (
  input  logic                         clk_i,
  input  logic                         we_i,
  input  logic [spfc_pkg::IDX_W-1:0]   waddr_i,
  input  spfc_pkg::seg_entry_t         wdata_i,
  input  logic [spfc_pkg::IDX_W-1:0]   raddr_i,
  output spfc_pkg::seg_entry_t         rdata_o
);

  spfc_pkg::seg_entry_t mem_q [spfc_pkg::MAX_SEGMENTS];
  spfc_pkg::seg_entry_t rdata_q;

  // Write from load commands
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read, follows the address every cycle
  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- hw/rtl/segment_page_fault_classifier_top.sv -----
// Top level: segment page fault classifier with sequencer over a shared adder.
//
//   channel | direction | handshake              | beat carries
//   cfg     | in        | cfg_valid_i/cfg_ready_o | segment_count
//   in      | in        | in_valid_i/in_ready_o   | load command or fault address
//   out     | out       | out_valid_o/out_ready_i | one result per fault command
//
// A load beat writes the table as it is accepted. A fault beat steps through the
// fault counter, each table entry walked (registered table read, base and end
// compares), the hit steps (file size, file offset, allocation count, last page,
// slack) and the hand-off of the result, paced by the one shared 33-bit adder.
// The input is not ready while a fault is in work. A finished result sits in the
// output register; the next beat is accepted while it waits to be taken.
// Reset clears the counters, segment_count and control; the table is not cleared.
module segment_page_fault_classifier_top (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // configuration
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [spfc_pkg::CFG_W-1:0]      cfg_segment_count_i,
  // input items
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic                            cmd_i,
  input  logic [2:0]                      entry_index_i,
  input  logic [31:0]                     segment_type_i,
  input  logic [31:0]                     segment_base_i,
  input  logic [31:0]                     memory_size_i,
  input  logic [31:0]                     file_size_i,
  input  logic [31:0]                     file_start_i,
  input  logic [31:0]                     fault_address_i,
  // results
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic                            mapped_o,
  output logic [31:0]                     page_base_o,
  output logic                            from_file_o,
  output logic [31:0]                     page_file_offset_o,
  output logic [spfc_pkg::ZF_W-1:0]       zero_from_o,
  output logic [spfc_pkg::HIT_W-1:0]      segment_hit_o,
  output logic [31:0]                     faults_seen_o,
  output logic [31:0]                     pages_allocated_o,
  output logic [31:0]                     fragmentation_bytes_o
);

  localparam int unsigned PB = spfc_pkg::PAGE_BITS;
  localparam int unsigned DW = spfc_pkg::DATA_W;

  // Sequencer states
  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_FCNT  = 4'd1;
  localparam logic [3:0] S_BASE  = 4'd2;
  localparam logic [3:0] S_MSZ   = 4'd3;
  localparam logic [3:0] S_WAIT  = 4'd4;
  localparam logic [3:0] S_FSZ   = 4'd5;
  localparam logic [3:0] S_FOFF  = 4'd6;
  localparam logic [3:0] S_ALLOC = 4'd7;
  localparam logic [3:0] S_LAST  = 4'd8;
  localparam logic [3:0] S_SLACK = 4'd9;
  localparam logic [3:0] S_DONE  = 4'd10;

  logic [3:0]                  state_q, state_d;
  logic [spfc_pkg::CNT_W-1:0]  idx_q, idx_d;
  logic [spfc_pkg::CNT_W-1:0]  limit_q, limit_d;
  logic [spfc_pkg::CFG_W-1:0]  seg_count_q;
  logic [DW-1:0]               page_q, page_d;
  logic [DW-1:0]               off_q, off_d;
  logic                        mapped_q, mapped_d;
  logic                        ff_q, ff_d;
  logic [DW-1:0]               foff_q, foff_d;
  logic [spfc_pkg::ZF_W-1:0]   zf_q, zf_d;
  logic [PB-1:0]               slack_add_q, slack_add_d;
  logic [DW-1:0]               fault_q, fault_d;
  logic [DW-1:0]               alloc_q, alloc_d;
  logic [DW-1:0]               slack_q, slack_d;
  logic                        out_valid_q, out_valid_d;
  logic                        out_load;

  logic                        in_fire;
  logic                        tbl_we;
  spfc_pkg::seg_entry_t        tbl_wdata;
  spfc_pkg::seg_entry_t        ent;
  spfc_pkg::alu_req_t          alu_req;
  spfc_pkg::alu_rsp_t          alu_rsp;
  logic [spfc_pkg::CNT_W-1:0]  idx_inc;
  logic                        last_entry;
  logic [PB-1:0]               used;

  // Configuration port is always ready
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seg_count_q <= '0;
    end else if (cfg_valid_i) begin
      seg_count_q <= cfg_segment_count_i;
    end
  end

  assign in_ready_o = (state_q == S_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;

  // Table write on a load beat with an index in range
  assign tbl_we = in_fire && (cmd_i == spfc_pkg::CMD_LOAD)
                  && (32'(entry_index_i) < spfc_pkg::MAX_SEGMENTS);
  assign tbl_wdata.loadable   = (segment_type_i == spfc_pkg::LOAD_TYPE);
  assign tbl_wdata.base       = segment_base_i;
  assign tbl_wdata.mem_size   = memory_size_i;
  assign tbl_wdata.file_size  = file_size_i;
  assign tbl_wdata.file_start = file_start_i;

  spfc_seg_table u_table (
    .clk_i   (clk_i),
    .we_i    (tbl_we),
    .waddr_i (spfc_pkg::IDX_W'(entry_index_i)),
    .wdata_i (tbl_wdata),
    .raddr_i (idx_q[spfc_pkg::IDX_W-1:0]),
    .rdata_o (ent)
  );

  spfc_alu u_alu (
    .req_i (alu_req),
    .rsp_o (alu_rsp)
  );

  assign idx_inc    = idx_q + spfc_pkg::CNT_W'(1);
  assign last_entry = (idx_inc >= limit_q);
  assign used       = ent.mem_size[PB-1:0];

  // Sequencer and shared unit operand select
  always_comb begin
    state_d     = state_q;
    idx_d       = idx_q;
    limit_d     = limit_q;
    page_d      = page_q;
    off_d       = off_q;
    mapped_d    = mapped_q;
    ff_d        = ff_q;
    foff_d      = foff_q;
    zf_d        = zf_q;
    slack_add_d = slack_add_q;
    fault_d     = fault_q;
    alloc_d     = alloc_q;
    slack_d     = slack_q;
    out_load    = 1'b0;
    out_valid_d = out_valid_q && !out_ready_i;
    alu_req     = '{op: spfc_pkg::ALU_ADD, a: '0, b: '0};

    unique case (state_q)
      S_IDLE: begin
        if (in_fire && (cmd_i == spfc_pkg::CMD_FAULT)) begin
          page_d   = {fault_address_i[DW-1:PB], {PB{1'b0}}};
          idx_d    = '0;
          limit_d  = (32'(seg_count_q) < spfc_pkg::MAX_SEGMENTS)
                     ? spfc_pkg::CNT_W'(seg_count_q)
                     : spfc_pkg::CNT_W'(spfc_pkg::MAX_SEGMENTS);
          mapped_d = 1'b0;
          ff_d     = 1'b0;
          foff_d   = '0;
          zf_d     = '0;
          state_d  = S_FCNT;
        end
      end
      S_FCNT: begin
        alu_req = '{op: spfc_pkg::ALU_ADD, a: fault_q, b: DW'(1)};
        fault_d = alu_rsp.sat;
        state_d = (limit_q == '0) ? S_DONE : S_BASE;
      end
      S_BASE: begin
        // page - base, borrow means page below the segment
        alu_req = '{op: spfc_pkg::ALU_SUB, a: page_q, b: ent.base};
        off_d   = alu_rsp.res;
        if (ent.loadable && !alu_rsp.co) begin
          state_d = S_MSZ;
        end else if (last_entry) begin
          state_d = S_DONE;
        end else begin
          idx_d   = idx_inc;
          state_d = S_WAIT;
        end
      end
      S_MSZ: begin
        // offset < memory size is the 33-bit end check
        alu_req = '{op: spfc_pkg::ALU_SUB, a: off_q, b: ent.mem_size};
        if (alu_rsp.co) begin
          mapped_d = 1'b1;
          state_d  = S_FSZ;
        end else if (last_entry) begin
          state_d = S_DONE;
        end else begin
          idx_d   = idx_inc;
          state_d = S_WAIT;
        end
      end
      S_WAIT: begin
        state_d = S_BASE;
      end
      S_FSZ: begin
        // file_size - offset: bytes of file left from this page on
        alu_req = '{op: spfc_pkg::ALU_SUB, a: ent.file_size, b: off_q};
        if (!alu_rsp.co && (alu_rsp.res != '0)) begin
          ff_d = 1'b1;
          if (alu_rsp.res[DW-1:PB] == '0) begin
            zf_d = spfc_pkg::ZF_W'(alu_rsp.res[PB-1:0]);
          end else begin
            zf_d = spfc_pkg::ZF_W'(spfc_pkg::PAGE_BYTES);
          end
          state_d = S_FOFF;
        end else begin
          state_d = S_ALLOC;
        end
      end
      S_FOFF: begin
        alu_req = '{op: spfc_pkg::ALU_ADD, a: ent.file_start, b: off_q};
        foff_d  = alu_rsp.res;
        state_d = S_ALLOC;
      end
      S_ALLOC: begin
        alu_req = '{op: spfc_pkg::ALU_ADD, a: alloc_q, b: DW'(1)};
        alloc_d = alu_rsp.sat;
        state_d = S_LAST;
      end
      S_LAST: begin
        // last page when offset page number equals (memory size - 1) page number
        alu_req = '{op: spfc_pkg::ALU_SUB, a: ent.mem_size, b: DW'(1)};
        if ((alu_rsp.res[DW-1:PB] == off_q[DW-1:PB]) && (used != '0)) begin
          slack_add_d = PB'(0) - used;
          state_d     = S_SLACK;
        end else begin
          state_d = S_DONE;
        end
      end
      S_SLACK: begin
        alu_req = '{op: spfc_pkg::ALU_ADD, a: slack_q, b: DW'(slack_add_q)};
        slack_d = alu_rsp.sat;
        state_d = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          out_load    = 1'b1;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control and counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      idx_q       <= '0;
      limit_q     <= '0;
      fault_q     <= '0;
      alloc_q     <= '0;
      slack_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      idx_q       <= idx_d;
      limit_q     <= limit_d;
      fault_q     <= fault_d;
      alloc_q     <= alloc_d;
      slack_q     <= slack_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Per-fault working registers
  always_ff @(posedge clk_i) begin
    page_q      <= page_d;
    off_q       <= off_d;
    mapped_q    <= mapped_d;
    ff_q        <= ff_d;
    foff_q      <= foff_d;
    zf_q        <= zf_d;
    slack_add_q <= slack_add_d;
  end

  // Output register
  always_ff @(posedge clk_i) begin
    if (out_load) begin
      mapped_o              <= mapped_q;
      page_base_o           <= page_q;
      from_file_o           <= ff_q;
      page_file_offset_o    <= foff_q;
      zero_from_o           <= zf_q;
      segment_hit_o         <= mapped_q ? spfc_pkg::HIT_W'(idx_q) : '0;
      faults_seen_o         <= fault_q;
      pages_allocated_o     <= alloc_q;
      fragmentation_bytes_o <= slack_q;
    end
  end

  assign out_valid_o = out_valid_q;

`ifndef SYNTHESIS
  // Mapped faults never outnumber faults
  a_alloc_le_faults: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (pages_allocated_o <= faults_seen_o))
    else $error("pages_allocated exceeds faults_seen");

  // A miss reports no segment detail
  a_miss_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !mapped_o) |-> (!from_file_o && (page_file_offset_o == '0)
                                    && (zero_from_o == '0) && (segment_hit_o == '0)))
    else $error("miss carries segment fields");

  // A file-backed page zero-fills from within (0, page size]
  a_zero_from_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && from_file_o) |-> ((zero_from_o != '0)
      && (zero_from_o <= spfc_pkg::ZF_W'(spfc_pkg::PAGE_BYTES))))
    else $error("zero_from out of range on file page");

  // A fault beat makes the block busy
  a_fault_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && (cmd_i == spfc_pkg::CMD_FAULT)) |=> !in_ready_o)
    else $error("input ready right after a fault beat");

  // The walk never reads past the search limit
  a_idx_in_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == S_BASE) || (state_q == S_MSZ)) |-> (idx_q < limit_q))
    else $error("table walk beyond segment_count");
`endif

endmodule

// ----- tb/sv/segment_page_fault_classifier_checker.sv -----
// Checker: predicts each fault classification and compares it with the result channel.
module segment_page_fault_classifier_checker (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  // configuration channel
  input  logic                       cfg_valid_i,
  input  logic                       cfg_ready_i,
  input  logic [spfc_pkg::CFG_W-1:0] cfg_segment_count_i,
  // command channel
  input  logic                       in_valid_i,
  input  logic                       in_ready_i,
  input  logic                       cmd_i,
  input  logic [2:0]                 entry_index_i,
  input  logic [31:0]                segment_type_i,
  input  logic [31:0]                segment_base_i,
  input  logic [31:0]                memory_size_i,
  input  logic [31:0]                file_size_i,
  input  logic [31:0]                file_start_i,
  input  logic [31:0]                fault_address_i,
  // result channel
  input  logic                       out_valid_i,
  input  logic                       out_ready_i,
  input  logic                       mapped_i,
  input  logic [31:0]                page_base_i,
  input  logic                       from_file_i,
  input  logic [31:0]                page_file_offset_i,
  input  logic [spfc_pkg::ZF_W-1:0]  zero_from_i,
  input  logic [spfc_pkg::HIT_W-1:0] segment_hit_i,
  input  logic [31:0]                faults_seen_i,
  input  logic [31:0]                pages_allocated_i,
  input  logic [31:0]                fragmentation_bytes_i,
  // status toward the test top
  output int                         mismatches_o,
  output int                         outstanding_o,
  output int                         results_checked_o,
  output int                         mapped_results_o
);

  localparam logic [63:0] PAGE_LEN  = 64'(spfc_pkg::PAGE_BYTES);
  localparam logic [31:0] PAGE_MASK = ~32'(spfc_pkg::PAGE_BYTES - 1);

  // Expected content of one result beat
  typedef struct packed {
    logic                        mapped;
    logic [31:0]                 page_base;
    logic                        from_file;
    logic [31:0]                 file_offset;
    logic [spfc_pkg::ZF_W-1:0]   zero_from;
    logic [spfc_pkg::HIT_W-1:0]  hit;
    logic [31:0]                 faults;
    logic [31:0]                 allocs;
    logic [31:0]                 slack;
  } fault_report_t;

  // Predicted block state
  spfc_pkg::seg_entry_t        seg_table [spfc_pkg::MAX_SEGMENTS];
  logic [spfc_pkg::CFG_W-1:0]  seg_count;
  logic [31:0]                 fault_total;
  logic [31:0]                 alloc_total;
  logic [31:0]                 slack_total;

  fault_report_t     expected_reports [$];
  fault_report_t     want;
  int                mismatches;
  int                results_checked;
  int                mapped_results;

  task automatic report_error(input string msg);
    $display("[%0t] result %0d: %s", $time, results_checked, msg);
    mismatches++;
  endtask

  task automatic check_field(input string name, input logic [31:0] got,
                             input logic [31:0] exp_val);
    if (got !== exp_val)
      report_error($sformatf("%s is 0x%08h, expected 0x%08h", name, got, exp_val));
  endtask

  // Add with clamp at all ones
  function automatic logic [31:0] sat_add(input logic [31:0] acc, input logic [63:0] amount);
    logic [63:0] sum;
    sum = {32'd0, acc} + amount;
    return (sum > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : sum[31:0];
  endfunction

  // Walk the table for the first loadable segment holding the page; updates totals
  function automatic fault_report_t classify_fault(input logic [31:0] addr);
    fault_report_t r;
    logic [63:0]   page;
    logic [63:0]   base;
    logic [63:0]   msz;
    logic [63:0]   fsz;
    logic [63:0]   off;
    logic [63:0]   tail;
    logic [63:0]   pages_needed;
    logic [63:0]   used;
    int            limit;
    int            i;
    bit            found;
    r           = '0;
    page        = {32'd0, addr & PAGE_MASK};
    fault_total = sat_add(fault_total, 64'd1);
    limit       = (seg_count < spfc_pkg::MAX_SEGMENTS) ? int'(seg_count)
                                                       : int'(spfc_pkg::MAX_SEGMENTS);
    found       = 1'b0;
    for (i = 0; i < limit; i++) begin
      base = {32'd0, seg_table[i].base};
      msz  = {32'd0, seg_table[i].mem_size};
      if (!found && seg_table[i].loadable && page >= base && page < base + msz) begin
        found    = 1'b1;
        off      = page - base;
        fsz      = {32'd0, seg_table[i].file_size};
        r.mapped = 1'b1;
        r.hit    = i[spfc_pkg::HIT_W-1:0];
        if (off < fsz) begin
          r.from_file   = 1'b1;
          r.file_offset = seg_table[i].file_start + off[31:0];
          tail          = fsz - off;
          r.zero_from   = (tail < PAGE_LEN) ? tail[spfc_pkg::ZF_W-1:0]
                                            : PAGE_LEN[spfc_pkg::ZF_W-1:0];
        end
        alloc_total  = sat_add(alloc_total, 64'd1);
        // slack only on the segment's last page, when the size is not page aligned
        pages_needed = (msz + PAGE_LEN - 64'd1) >> spfc_pkg::PAGE_BITS;
        used         = msz & (PAGE_LEN - 64'd1);
        if (pages_needed != 0 && (off >> spfc_pkg::PAGE_BITS) == pages_needed - 64'd1
            && used != 0)
          slack_total = sat_add(slack_total, PAGE_LEN - used);
      end
    end
    r.page_base = page[31:0];
    r.faults    = fault_total;
    r.allocs    = alloc_total;
    r.slack     = slack_total;
    return r;
  endfunction

  // Track beats on all three channels
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seg_count       = '0;
      fault_total     = '0;
      alloc_total     = '0;
      slack_total     = '0;
      mismatches      = 0;
      results_checked = 0;
      mapped_results  = 0;
      expected_reports.delete();
    end else begin
      if (cfg_valid_i && cfg_ready_i)
        seg_count = cfg_segment_count_i;

      // result beat against the oldest expectation
      if (out_valid_i && out_ready_i) begin
        if (expected_reports.size() == 0) begin
          report_error("result beat with no fault outstanding");
        end else begin
          want = expected_reports.pop_front();
          check_field("mapped", 32'(mapped_i), 32'(want.mapped));
          check_field("page_base", page_base_i, want.page_base);
          check_field("from_file", 32'(from_file_i), 32'(want.from_file));
          check_field("page_file_offset", page_file_offset_i, want.file_offset);
          check_field("zero_from", 32'(zero_from_i), 32'(want.zero_from));
          check_field("segment_hit", 32'(segment_hit_i), 32'(want.hit));
          check_field("faults_seen", faults_seen_i, want.faults);
          check_field("pages_allocated", pages_allocated_i, want.allocs);
          check_field("fragmentation_bytes", fragmentation_bytes_i, want.slack);
          if (want.mapped)
            mapped_results++;
        end
        results_checked++;
      end

      // command beat: table write or new fault
      if (in_valid_i && in_ready_i) begin
        if (cmd_i == spfc_pkg::CMD_LOAD) begin
          seg_table[entry_index_i].loadable   = (segment_type_i == spfc_pkg::LOAD_TYPE);
          seg_table[entry_index_i].base       = segment_base_i;
          seg_table[entry_index_i].mem_size   = memory_size_i;
          seg_table[entry_index_i].file_size  = file_size_i;
          seg_table[entry_index_i].file_start = file_start_i;
        end else begin
          expected_reports.push_back(classify_fault(fault_address_i));
        end
      end
    end
    mismatches_o      <= mismatches;
    outstanding_o     <= expected_reports.size();
    results_checked_o <= results_checked;
    mapped_results_o  <= mapped_results;
  end

endmodule

// ----- tb/sv/segment_page_fault_classifier_top_test.sv -----
// Test top: drives table loads, faults and segment-count writes into the classifier.
module segment_page_fault_classifier_top_test;

  localparam int SETTLE_CYCLES = 40;   // longer than the slowest fault walk
  localparam int PHASES        = 8;
  localparam int PHASE_ITEMS   = 200;
  localparam logic [31:0] LOADABLE = spfc_pkg::LOAD_TYPE;

  // One command beat as driven on the input channel
  typedef struct packed {
    spfc_pkg::cmd_e  cmd;
    logic [2:0]      entry;
    logic [31:0]     seg_type;
    logic [31:0]     base;
    logic [31:0]     mem_size;
    logic [31:0]     file_size;
    logic [31:0]     file_start;
    logic [31:0]     addr;
  } paging_req_t;

  logic                        clk_i;
  logic                        rst_ni;
  logic                        cfg_valid_i;
  logic                        cfg_ready_o;
  logic [spfc_pkg::CFG_W-1:0]  cfg_segment_count_i;
  logic                        in_valid_i;
  logic                        in_ready_o;
  logic                        cmd_i;
  logic [2:0]                  entry_index_i;
  logic [31:0]                 segment_type_i;
  logic [31:0]                 segment_base_i;
  logic [31:0]                 memory_size_i;
  logic [31:0]                 file_size_i;
  logic [31:0]                 file_start_i;
  logic [31:0]                 fault_address_i;
  logic                        out_valid_o;
  logic                        out_ready_i;
  logic                        mapped_o;
  logic [31:0]                 page_base_o;
  logic                        from_file_o;
  logic [31:0]                 page_file_offset_o;
  logic [spfc_pkg::ZF_W-1:0]   zero_from_o;
  logic [spfc_pkg::HIT_W-1:0]  segment_hit_o;
  logic [31:0]                 faults_seen_o;
  logic [31:0]                 pages_allocated_o;
  logic [31:0]                 fragmentation_bytes_o;

  int                mismatches;
  int                outstanding;
  int                results_checked;
  int                mapped_results;

  // Stimulus-side copy of the table, used only to aim faults at segments
  logic [31:0]       aim_base [spfc_pkg::MAX_SEGMENTS];
  logic [31:0]       aim_size [spfc_pkg::MAX_SEGMENTS];
  bit                idle_on;
  int                loads_sent;
  int                faults_sent;
  int                cfg_writes;

  segment_page_fault_classifier_top DUT (
    .clk_i                 (clk_i),
    .rst_ni                (rst_ni),
    .cfg_valid_i           (cfg_valid_i),
    .cfg_ready_o           (cfg_ready_o),
    .cfg_segment_count_i   (cfg_segment_count_i),
    .in_valid_i            (in_valid_i),
    .in_ready_o            (in_ready_o),
    .cmd_i                 (cmd_i),
    .entry_index_i         (entry_index_i),
    .segment_type_i        (segment_type_i),
    .segment_base_i        (segment_base_i),
    .memory_size_i         (memory_size_i),
    .file_size_i           (file_size_i),
    .file_start_i          (file_start_i),
    .fault_address_i       (fault_address_i),
    .out_valid_o           (out_valid_o),
    .out_ready_i           (out_ready_i),
    .mapped_o              (mapped_o),
    .page_base_o           (page_base_o),
    .from_file_o           (from_file_o),
    .page_file_offset_o    (page_file_offset_o),
    .zero_from_o           (zero_from_o),
    .segment_hit_o         (segment_hit_o),
    .faults_seen_o         (faults_seen_o),
    .pages_allocated_o     (pages_allocated_o),
    .fragmentation_bytes_o (fragmentation_bytes_o)
  );

  segment_page_fault_classifier_checker u_check (
    .clk_i                 (clk_i),
    .rst_ni                (rst_ni),
    .cfg_valid_i           (cfg_valid_i),
    .cfg_ready_i           (cfg_ready_o),
    .cfg_segment_count_i   (cfg_segment_count_i),
    .in_valid_i            (in_valid_i),
    .in_ready_i            (in_ready_o),
    .cmd_i                 (cmd_i),
    .entry_index_i         (entry_index_i),
    .segment_type_i        (segment_type_i),
    .segment_base_i        (segment_base_i),
    .memory_size_i         (memory_size_i),
    .file_size_i           (file_size_i),
    .file_start_i          (file_start_i),
    .fault_address_i       (fault_address_i),
    .out_valid_i           (out_valid_o),
    .out_ready_i           (out_ready_i),
    .mapped_i              (mapped_o),
    .page_base_i           (page_base_o),
    .from_file_i           (from_file_o),
    .page_file_offset_i    (page_file_offset_o),
    .zero_from_i           (zero_from_o),
    .segment_hit_i         (segment_hit_o),
    .faults_seen_i         (faults_seen_o),
    .pages_allocated_i     (pages_allocated_o),
    .fragmentation_bytes_i (fragmentation_bytes_o),
    .mismatches_o          (mismatches),
    .outstanding_o         (outstanding),
    .results_checked_o     (results_checked),
    .mapped_results_o      (mapped_results)
  );

  // Clock
  initial clk_i = 1'b0;
  always #10 clk_i = ~clk_i;

  // Run limit: fail and stop if the stimulus never finishes
  initial begin
    #12_000_000;
    $display("segment_page_fault_classifier_top_test: FAIL");
    $finish;
  end

  // Result side back-pressure in random bursts
  initial begin
    out_ready_i <= 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      if (idle_on && $urandom_range(0, 4) == 0) begin
        out_ready_i <= 1'b0;
        repeat ($urandom_range(1, 14)) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      repeat ($urandom_range(1, 30)) @(posedge clk_i);
    end
  end

  // One command beat, with an optional idle burst in front of it
  task automatic send_req(input paging_req_t r);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk_i);
    end
    in_valid_i      <= 1'b1;
    cmd_i           <= r.cmd;
    entry_index_i   <= r.entry;
    segment_type_i  <= r.seg_type;
    segment_base_i  <= r.base;
    memory_size_i   <= r.mem_size;
    file_size_i     <= r.file_size;
    file_start_i    <= r.file_start;
    fault_address_i <= r.addr;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    if (r.cmd == spfc_pkg::CMD_LOAD) begin
      aim_base[r.entry] = r.base;
      aim_size[r.entry] = r.mem_size;
      loads_sent++;
    end else begin
      faults_sent++;
    end
  endtask

  task automatic load_entry(input logic [2:0] idx, input logic [31:0] seg_type,
                            input logic [31:0] base, input logic [31:0] mem_size,
                            input logic [31:0] file_size, input logic [31:0] file_start);
    paging_req_t r;
    r = '{spfc_pkg::CMD_LOAD, idx, seg_type, base, mem_size, file_size, file_start,
          $urandom};
    send_req(r);
  endtask

  task automatic fault_at(input logic [31:0] addr);
    paging_req_t r;
    r = '{spfc_pkg::CMD_FAULT, 3'($urandom), $urandom, $urandom, $urandom, $urandom,
          $urandom, addr};
    send_req(r);
  endtask

  // Drop valid and let every outstanding fault come back
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (outstanding != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic set_segment_count(input logic [spfc_pkg::CFG_W-1:0] count);
    wait_idle();
    cfg_valid_i         <= 1'b1;
    cfg_segment_count_i <= count;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    cfg_writes++;
  endtask

  // Stimulus and verdict
  initial begin
    paging_req_t                 r;
    logic [spfc_pkg::CFG_W-1:0]  count;
    logic [31:0]                 span;
    logic [31:0]                 m;
    int                          pick;

    idle_on             = 1'b1;
    loads_sent          = 0;
    faults_sent         = 0;
    cfg_writes          = 0;
    rst_ni              <= 1'b0;
    cfg_valid_i         <= 1'b0;
    cfg_segment_count_i <= '0;
    in_valid_i          <= 1'b0;
    cmd_i               <= spfc_pkg::CMD_LOAD;
    entry_index_i       <= '0;
    segment_type_i      <= '0;
    segment_base_i      <= '0;
    memory_size_i       <= '0;
    file_size_i         <= '0;
    file_start_i        <= '0;
    fault_address_i     <= '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: nothing searched while the count is still zero
    fault_at(32'h0000_1234);

    // Fill the whole table before any entry can be searched
    load_entry(3'd0, LOADABLE,      32'h0000_0000, 32'h0000_2800, 32'h0000_1100, 32'h0000_1000);
    load_entry(3'd1, 32'h0,         32'h0001_0000, 32'h0000_1000, 32'h0000_1000, 32'h0000_0000);
    load_entry(3'd2, 32'hFFFF_FFFF, 32'h0002_0000, 32'h0000_1000, 32'h0000_1000, 32'h0000_0000);
    load_entry(3'd3, LOADABLE,      32'hFFFF_F000, 32'h0000_2000, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    load_entry(3'd4, LOADABLE,      32'h0040_0000, 32'h0000_0000, 32'h0000_0000, 32'h1234_5678);
    load_entry(3'd5, LOADABLE,      32'h0050_0800, 32'h0000_3000, 32'h0000_2000, 32'hFFFF_F000);
    load_entry(3'd6, LOADABLE,      32'h0060_0000, 32'h0000_1001, 32'h0000_0000, 32'h0000_0000);
    load_entry(3'd7, LOADABLE,      32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0010, 32'h8000_0000);

    set_segment_count(4'd8);
    fault_at(32'h0000_0000);   // first page, fully backed by the file
    fault_at(32'h0000_1ABC);   // file ends inside the page
    fault_at(32'h0000_2FFF);   // zero-fill last page, slack counted
    fault_at(32'h0001_0000);   // non-loadable entry skipped
    fault_at(32'hFFFF_FFFF);   // segment end beyond 32 bits
    fault_at(32'h0040_0000);   // empty segment never matches
    fault_at(32'h0050_1800);   // unaligned segment base
    fault_at(32'h0050_2ABC);   // file offset wraps past 2^32
    fault_at(32'h0050_3000);   // aligned last page, no slack
    fault_at(32'h0060_1000);   // one used byte on the last page
    fault_at(32'h8000_0000);   // only the catch-all entry holds it
    set_segment_count(4'd15);  // above the table size: searches all
    fault_at(32'hFFFF_F123);
    set_segment_count(4'd3);   // upper entries left out: miss
    fault_at(32'h8000_0000);
    fault_at(32'h0000_0FFF);

    // Random phases, each opened by a segment-count write
    for (int phase = 0; phase < PHASES; phase++) begin
      case (phase)
        0:       count = 4'd15;
        1:       count = 4'd0;
        2:       count = 4'd1;
        3:       count = 4'd3;
        5:       count = spfc_pkg::CFG_W'($urandom_range(0, 15));
        6:       count = 4'd6;
        default: count = 4'd8;
      endcase
      if (phase == PHASES - 1)
        idle_on = 1'b0;
      set_segment_count(count);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        // mid-phase drain so the block sees an empty pipe
        if (n == PHASE_ITEMS / 2)
          wait_idle();
        if ($urandom_range(0, 3) == 0) begin
          r.cmd   = spfc_pkg::CMD_LOAD;
          r.entry = 3'($urandom_range(0, 7));
          case ($urandom_range(0, 9))
            0:       r.seg_type = $urandom;
            1:       r.seg_type = '0;
            default: r.seg_type = LOADABLE;
          endcase
          case ($urandom_range(0, 3))
            0:       r.base = $urandom;
            1:       r.base = 32'hFFFF_0000 | $urandom_range(0, 32'hFFFF);
            default: r.base = ($urandom_range(0, 63) << 14) |
                              ($urandom_range(0, 1) ? 32'd0
                               : $urandom_range(0, spfc_pkg::PAGE_BYTES - 1));
          endcase
          case ($urandom_range(0, 9))
            0:       r.mem_size = '0;
            1:       r.mem_size = 32'hFFFF_FFFF;
            2:       r.mem_size = $urandom;
            3, 4:    r.mem_size = $urandom_range(1, 6) << spfc_pkg::PAGE_BITS;
            default: r.mem_size = $urandom_range(1, 6 * spfc_pkg::PAGE_BYTES);
          endcase
          case ($urandom_range(0, 4))
            0:       r.file_size = '0;
            1:       r.file_size = r.mem_size;
            2:       r.file_size = $urandom;
            default: r.file_size = $urandom_range(0, r.mem_size);
          endcase
          r.file_start = $urandom;
          r.addr       = $urandom;
        end else begin
          r = '{spfc_pkg::CMD_FAULT, 3'($urandom), $urandom, $urandom, $urandom, $urandom,
                $urandom, 32'd0};
          if ($urandom_range(0, 4) != 0) begin
            // aim at a segment: start, last byte, inside, or just past the end
            pick = $urandom_range(0, spfc_pkg::MAX_SEGMENTS - 1);
            m    = aim_size[pick];
            case ($urandom_range(0, 3))
              0:       span = '0;
              1:       span = (m == 0) ? 32'd0 : m - 32'd1;
              2:       span = (m == 0) ? 32'd0 : $urandom_range(0, m - 32'd1);
              default: span = m;
            endcase
            r.addr = aim_base[pick] + span;
          end else begin
            r.addr = $urandom_range(0, 1) ? $urandom : $urandom_range(0, 32'h00FF_FFFF);
          end
        end
        send_req(r);
      end
    end

    wait_idle();
    $display("Covered %0d table loads and %0d faults over %0d segment-count writes.",
             loads_sent, faults_sent, cfg_writes);
    $display("Checked %0d results, %0d of them mapped to a segment.",
             results_checked, mapped_results);
    if (mismatches == 0 && outstanding == 0) begin
      $display("segment_page_fault_classifier_top_test: PASS");
    end else begin
      $display("segment_page_fault_classifier_top_test: FAIL");
    end
    $finish;
  end

endmodule
